/* sv/qhd_pkg.sv */
// Package for the hard-decision QAM demapper.
// Holds modulation codes, unit thresholds, the symbol struct and helpers.
// No dependencies.
package qhd_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned ScaleWidth  = 16;
  localparam int unsigned UnitWidth   = 12;
  localparam int unsigned OrderWidth  = 4;
  localparam int unsigned BitsWidth   = 8;
  localparam int unsigned CmpWidth    = 19;
  localparam int unsigned FracBits    = 12;

  localparam logic [OrderWidth-1:0] BpsQpsk   = 4'd2;
  localparam logic [OrderWidth-1:0] BpsQam16  = 4'd4;
  localparam logic [OrderWidth-1:0] BpsQam64  = 4'd6;
  localparam logic [OrderWidth-1:0] BpsQam256 = 4'd8;
  localparam logic [OrderWidth-1:0] BpsReset  = BpsQpsk;

  localparam logic [UnitWidth-1:0] UnitQam16  = 12'd2591;
  localparam logic [UnitWidth-1:0] UnitQam64  = 12'd1264;
  localparam logic [UnitWidth-1:0] UnitQam256 = 12'd628;

  typedef struct packed {
    logic [SampleWidth-1:0] ax;
    logic [SampleWidth-1:0] ay;
    logic                   x_neg;
    logic                   y_neg;
    logic                   y_zero;
  } qhd_sym_t;

  function automatic logic [UnitWidth-1:0] unit_of(input logic [OrderWidth-1:0] order);
    logic [UnitWidth-1:0] u;
    unique case (order)
      BpsQam16:  u = UnitQam16;
      BpsQam64:  u = UnitQam64;
      BpsQam256: u = UnitQam256;
      default:   u = '0;
    endcase
    return u;
  endfunction

  function automatic logic signed [CmpWidth-1:0] abs_c(input logic signed [CmpWidth-1:0] v);
    return v[CmpWidth-1] ? -v : v;
  endfunction

endpackage

/* sv/qhd_threshold.sv */
// Base threshold of the hard demapper: unit constant times channel scale
// (the unit alone when the scale is zero). Depends on qhd_pkg.
module qhd_threshold import qhd_pkg::*; (
  input  logic [OrderWidth-1:0]  order_i,
  input  logic [ScaleWidth-1:0]  scale_i,
  output logic [SampleWidth-1:0] thresh_o
);

  logic [UnitWidth-1:0]            unit;
  logic [UnitWidth+ScaleWidth-1:0] prod;

  assign unit = unit_of(order_i);
  assign prod = unit * scale_i;

  always_comb begin
    if (scale_i == '0) begin
      thresh_o = SampleWidth'(unit);
    end else begin
      thresh_o = prod[FracBits +: SampleWidth];
    end
  end

endmodule

/* sv/qhd_decide.sv */
// Hard-decision logic: sign tests and folded-magnitude compares.
// Depends on qhd_pkg.
module qhd_decide import qhd_pkg::*; (
  input  logic [OrderWidth-1:0]  order_i,
  input  qhd_sym_t               sym_i,
  input  logic [SampleWidth-1:0] thresh_i,
  output logic [BitsWidth-1:0]   bits_o
);

  logic signed [CmpWidth-1:0] ax, ay, a1, a2, a3, a4, fx, fy;

  assign ax = $signed(CmpWidth'(sym_i.ax));
  assign ay = $signed(CmpWidth'(sym_i.ay));
  assign a1 = $signed(CmpWidth'(thresh_i));
  assign a2 = a1 <<< 1;
  assign a3 = a2 + a1;
  assign a4 = a1 <<< 2;
  assign fx = abs_c(ax - a4);
  assign fy = abs_c(ay - a4);

  always_comb begin
    bits_o = '0;
    unique case (order_i)
      BpsQpsk: begin
        bits_o[0] = sym_i.y_neg;
        bits_o[1] = !sym_i.x_neg;
      end
      BpsQam16: begin
        bits_o[0] = ay <= a1;
        bits_o[1] = sym_i.y_neg;
        bits_o[2] = ax <= a1;
        bits_o[3] = !sym_i.x_neg;
      end
      BpsQam64: begin
        bits_o[0] = (ay >= a1) && (ay <= a3);
        bits_o[1] = ay <= a2;
        bits_o[2] = sym_i.y_neg || sym_i.y_zero;
        bits_o[3] = (ax >= a1) && (ax <= a3);
        bits_o[4] = ax <= a2;
        bits_o[5] = !sym_i.x_neg;
      end
      BpsQam256: begin
        bits_o[0] = abs_c(fy - a2) <= a1;
        bits_o[1] = fy <= a2;
        bits_o[2] = ay <= a4;
        bits_o[3] = sym_i.y_neg || sym_i.y_zero;
        bits_o[4] = abs_c(fx - a2) <= a1;
        bits_o[5] = fx <= a2;
        bits_o[6] = ax <= a4;
        bits_o[7] = !sym_i.x_neg;
      end
      default: bits_o = '0;
    endcase
  end

endmodule

/* sv/qam_hard_demapper.sv */
// Top level of the hard-decision Gray QAM demapper.
// Depends on qhd_pkg, qhd_threshold and qhd_decide.
//
// The block takes one symbol word per clock unless stalled and returns one word
// of hard bits per symbol, via an input register, a register after the threshold
// multiplier, and the result register. Stages advance whenever the next one is
// free, so a stalled output only stops input once all stages are full. Write the
// modulation order over the configuration channel only while no word is in flight
// (not enforced by the block); it resets to QPSK, unsupported orders give zeros.
module qam_hard_demapper import qhd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,     // bits_per_symbol
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // in_phase, quadrature, channel_scale
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // hard_bits
);

  logic [OrderWidth-1:0] order_q;

  logic                   v1_q, v2_q, v3_q;
  logic                   adv1, adv2, adv3;
  logic [SampleWidth-1:0] x_q, y_q;
  logic [ScaleWidth-1:0]  s_q;
  qhd_sym_t               sym_d, sym_q;
  logic [SampleWidth-1:0] thr_d, thr_q;
  logic [BitsWidth-1:0]   bits_d, bits_q;

  assign cfg_ready_o = 1'b1;

  assign adv3 = !v3_q || m_axis_tready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign s_axis_tready = adv1;

  assign sym_d.x_neg  = x_q[SampleWidth-1];
  assign sym_d.y_neg  = y_q[SampleWidth-1];
  assign sym_d.y_zero = (y_q == '0);
  assign sym_d.ax     = x_q[SampleWidth-1] ? (~x_q + 1'b1) : x_q;
  assign sym_d.ay     = y_q[SampleWidth-1] ? (~y_q + 1'b1) : y_q;

  qhd_threshold u_threshold (
    .order_i  (order_q),
    .scale_i  (s_q),
    .thresh_o (thr_d)
  );

  qhd_decide u_decide (
    .order_i  (order_q),
    .sym_i    (sym_q),
    .thresh_i (thr_q),
    .bits_o   (bits_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= BpsReset;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        order_q <= cfg_data_i;
      end
      if (adv1) begin
        v1_q <= s_axis_tvalid;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && s_axis_tvalid) begin
      x_q <= s_axis_tdata[15:0];
      y_q <= s_axis_tdata[31:16];
      s_q <= s_axis_tdata[47:32];
    end
    if (adv2 && v1_q) begin
      sym_q <= sym_d;
      thr_q <= thr_d;
    end
    if (adv3 && v2_q) begin
      bits_q <= bits_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = bits_q;

endmodule
